@@ design/cht_pkg.sv @@
`timescale 1ns / 1ps
package cht_pkg;

    localparam int OP_W  = 2;
    localparam int KEY_W = 31;
    localparam int PAY_W = 32;
    localparam int ST_W  = 2;
    localparam int CFG_W = 7;

    localparam int DEF_MAX_BUCKETS = 64;
    localparam int DEF_POOL_NODES  = 256;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        B_INIT,
        B_IDLE,
        B_HEAD,
        B_INS,
        B_NODE,
        B_REM
    } t_bstate;

endpackage

@@ design/cht_front.sv @@
`timescale 1ns / 1ps
module cht_front #(
    parameter int MAX_BUCKETS = cht_pkg::DEF_MAX_BUCKETS,
    parameter int BW          = 6,
    parameter int JW          = 71
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic [cht_pkg::CFG_W-1:0] i_bucket_count,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [cht_pkg::OP_W-1:0] i_op,
    input  logic [cht_pkg::KEY_W-1:0] i_key,
    input  logic [cht_pkg::PAY_W-1:0] i_payload,
    output logic                     o_push,
    input  logic                     i_full,
    output logic [JW-1:0]            o_job
);
    import cht_pkg::*;

    localparam int CW = $clog2(KEY_W);

    t_fstate            r_state, n_state;
    logic [OP_W-1:0]    r_op;
    logic [KEY_W-1:0]   r_key;
    logic [PAY_W-1:0]   r_pay;
    logic [KEY_W-1:0]   r_shift;
    logic [CFG_W-1:0]   r_rem;
    logic [CFG_W-1:0]   r_div;
    logic [CW-1:0]      r_cnt;
    logic [CFG_W:0]     w_rem2;
    logic [CFG_W-1:0]   w_div;
    logic               w_accept;

    // Bucket count zero acts as one; counts above the table size saturate.
    always_comb begin
        if (i_bucket_count == '0) begin
            w_div = CFG_W'(1);
        end else if (int'(i_bucket_count) > MAX_BUCKETS) begin
            w_div = CFG_W'(MAX_BUCKETS);
        end else begin
            w_div = i_bucket_count;
        end
    end

    assign w_accept = i_valid && o_ready;
    assign w_rem2   = {r_rem, r_shift[KEY_W-1]};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FR_IDLE: if (w_accept) n_state = FR_DIV;
            FR_DIV:  if (r_cnt == CW'(KEY_W - 1)) n_state = FR_PUSH;
            FR_PUSH: if (!i_full) n_state = FR_IDLE;
            default: n_state = FR_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == FR_IDLE) && i_en;
        o_push  = (r_state == FR_PUSH) && !i_full;
        o_job   = {r_op, r_key, r_pay, BW'(r_rem)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Restoring remainder, one key bit per cycle from the top.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_op;
            r_key   <= i_key;
            r_pay   <= i_payload;
            r_shift <= i_key;
            r_rem   <= '0;
            r_div   <= w_div;
            r_cnt   <= '0;
        end else if (r_state == FR_DIV) begin
            r_shift <= {r_shift[KEY_W-2:0], 1'b0};
            r_cnt   <= r_cnt + CW'(1);
            if (w_rem2 >= {1'b0, r_div}) begin
                r_rem <= CFG_W'(w_rem2 - {1'b0, r_div});
            end else begin
                r_rem <= CFG_W'(w_rem2);
            end
        end
    end

endmodule

@@ design/cht_queue.sv @@
`timescale 1ns / 1ps
module cht_queue #(
    parameter int W = 71
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    import cht_pkg::*;

    logic [W-1:0] r_slot [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wp] <= i_data;
    end

endmodule

@@ design/cht_back.sv @@
`timescale 1ns / 1ps
module cht_back #(
    parameter int MAX_BUCKETS = cht_pkg::DEF_MAX_BUCKETS,
    parameter int POOL_NODES  = cht_pkg::DEF_POOL_NODES,
    parameter int BW          = 6,
    parameter int JW          = 71
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    output logic                      o_init_done,
    input  logic                      i_job_valid,
    input  logic [JW-1:0]             i_job,
    output logic                      o_job_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [cht_pkg::ST_W-1:0]  o_status,
    output logic [cht_pkg::PAY_W-1:0] o_found
);
    import cht_pkg::*;

    localparam int NW       = $clog2(POOL_NODES);
    localparam int LW       = $clog2(POOL_NODES + 1);
    localparam int SW       = LW;
    localparam int INIT_LEN = (MAX_BUCKETS > POOL_NODES) ? MAX_BUCKETS : POOL_NODES;
    localparam int IW       = $clog2(INIT_LEN + 1);
    localparam logic [LW-1:0] EMPTY = LW'(POOL_NODES);

    logic [LW-1:0]    m_heads [MAX_BUCKETS];
    logic [KEY_W-1:0] m_keys  [POOL_NODES];
    logic [PAY_W-1:0] m_pays  [POOL_NODES];
    logic [LW-1:0]    m_links [POOL_NODES];

    logic [LW-1:0]    r_head_q, r_link_q;
    logic [KEY_W-1:0] r_key_q;
    logic [PAY_W-1:0] r_pay_q;

    t_bstate          r_state, n_state;
    logic [IW-1:0]    r_init;
    logic [OP_W-1:0]  r_op;
    logic [KEY_W-1:0] r_key;
    logic [PAY_W-1:0] r_pay;
    logic [BW-1:0]    r_bkt;
    logic [LW-1:0]    r_cur, r_prev, r_node, r_free;
    logic [SW-1:0]    r_steps;
    logic             r_out_valid;
    logic [ST_W-1:0]  r_status;
    logic [PAY_W-1:0] r_found;

    logic [OP_W-1:0]  w_jop;
    logic [KEY_W-1:0] w_jkey;
    logic [PAY_W-1:0] w_jpay;
    logic [BW-1:0]    w_jbkt;

    logic             hd_we;
    logic [BW-1:0]    hd_waddr;
    logic [LW-1:0]    hd_wdata;
    logic             ln_we;
    logic [NW-1:0]    ln_waddr;
    logic [LW-1:0]    ln_wdata;
    logic             kp_we;
    logic [NW-1:0]    kp_waddr;
    logic [NW-1:0]    rd_addr;
    logic             w_start, w_finish, w_match;
    logic [ST_W-1:0]  w_status;
    logic [PAY_W-1:0] w_found;

    assign {w_jop, w_jkey, w_jpay, w_jbkt} = i_job;
    assign w_start = (r_state == B_IDLE) && i_job_valid && !r_out_valid;
    assign w_match = (r_key_q == r_key);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_INIT: if (r_init == IW'(INIT_LEN - 1)) n_state = B_IDLE;
            B_IDLE: if (w_start) n_state = B_HEAD;
            B_HEAD: begin
                if (r_op == OP_INSERT && r_free < EMPTY) begin
                    n_state = B_INS;
                end else if ((r_op == OP_LOOKUP || r_op == OP_REMOVE) && r_head_q < EMPTY) begin
                    n_state = B_NODE;
                end else begin
                    n_state = B_IDLE;
                end
            end
            B_INS:  n_state = B_IDLE;
            B_NODE: begin
                if (w_match && r_op == OP_REMOVE) begin
                    n_state = B_REM;
                end else if (w_match || r_link_q >= EMPTY
                             || r_steps == SW'(POOL_NODES - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_REM:  n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        hd_we    = 1'b0;
        hd_waddr = r_bkt;
        hd_wdata = r_node;
        ln_we    = 1'b0;
        ln_waddr = r_node[NW-1:0];
        ln_wdata = r_cur;
        kp_we    = 1'b0;
        kp_waddr = r_free[NW-1:0];
        rd_addr  = r_link_q[NW-1:0];
        w_finish = 1'b0;
        w_status = ST_MISS;
        w_found  = '0;
        unique case (r_state)
            B_INIT: begin
                hd_we    = int'(r_init) < MAX_BUCKETS;
                hd_waddr = r_init[BW-1:0];
                hd_wdata = EMPTY;
                ln_we    = int'(r_init) < POOL_NODES;
                ln_waddr = r_init[NW-1:0];
                ln_wdata = LW'(r_init) + LW'(1);
            end
            B_IDLE: ;
            B_HEAD: begin
                if (r_op == OP_INSERT) begin
                    rd_addr = r_free[NW-1:0];
                    if (r_free < EMPTY) begin
                        kp_we    = 1'b1;
                        hd_we    = 1'b1;
                        hd_wdata = r_free;
                    end else begin
                        w_finish = 1'b1;
                        w_status = ST_FULL;
                    end
                end else begin
                    rd_addr = r_head_q[NW-1:0];
                    if (!((r_op == OP_LOOKUP || r_op == OP_REMOVE) && r_head_q < EMPTY)) begin
                        w_finish = 1'b1;
                    end
                end
            end
            B_INS: begin
                // The old chain head follows the new node.
                ln_we    = 1'b1;
                ln_waddr = r_node[NW-1:0];
                ln_wdata = r_cur;
                w_finish = 1'b1;
                w_status = ST_DONE;
            end
            B_NODE: begin
                if (w_match) begin
                    if (r_op == OP_REMOVE) begin
                        if (r_prev >= EMPTY) begin
                            hd_we    = 1'b1;
                            hd_wdata = r_link_q;
                        end else begin
                            ln_we    = 1'b1;
                            ln_waddr = r_prev[NW-1:0];
                            ln_wdata = r_link_q;
                        end
                    end else begin
                        w_finish = 1'b1;
                        w_status = ST_DONE;
                        w_found  = r_pay_q;
                    end
                end else if (r_link_q >= EMPTY || r_steps == SW'(POOL_NODES - 1)) begin
                    w_finish = 1'b1;
                end
            end
            B_REM: begin
                // The freed node goes back on top of the free list.
                ln_we    = 1'b1;
                ln_waddr = r_cur[NW-1:0];
                ln_wdata = r_free;
                w_finish = 1'b1;
                w_status = ST_DONE;
            end
            default: ;
        endcase
    end

    assign o_init_done = (r_state != B_INIT);
    assign o_job_pop   = w_start;
    assign o_valid     = r_out_valid;
    assign o_status    = r_status;
    assign o_found     = r_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_INIT;
            r_init      <= '0;
            r_free      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_INIT) r_init <= r_init + IW'(1);
            if (r_state == B_INS) r_free <= r_link_q;
            if (r_state == B_REM) r_free <= r_cur;
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_op  <= w_jop;
            r_key <= w_jkey;
            r_pay <= w_jpay;
            r_bkt <= w_jbkt;
        end
        if (r_state == B_HEAD) begin
            r_cur   <= r_head_q;
            r_node  <= r_free;
            r_prev  <= EMPTY;
            r_steps <= '0;
        end else if (r_state == B_NODE && !w_match) begin
            r_prev  <= r_cur;
            r_cur   <= r_link_q;
            r_steps <= r_steps + SW'(1);
        end
        if (w_finish) begin
            r_status <= w_status;
            r_found  <= w_found;
        end
    end

    // While walking, r_cur is held for the removal through the B_NODE exit.
    always_ff @(posedge i_clk) begin
        if (hd_we) m_heads[hd_waddr] <= hd_wdata;
        r_head_q <= m_heads[w_jbkt];
    end

    always_ff @(posedge i_clk) begin
        if (ln_we) m_links[ln_waddr] <= ln_wdata;
        r_link_q <= m_links[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (kp_we) m_keys[kp_waddr] <= r_key;
        r_key_q <= m_keys[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (kp_we) m_pays[kp_waddr] <= r_pay;
        r_pay_q <= m_pays[rd_addr];
    end

endmodule

@@ design/chained_hash_table_engine_top.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Width  Contents (lowest bit first)
// s_axis   in   72     opcode[1:0], key_id[32:2], record_payload[64:33]
// m_axis   out  40     status[1:0], found_payload[33:2]
// cfg      in   7      bucket_count, written when i_cfg_we is high
//
// After reset a clearing pass over max(MAX_BUCKETS, POOL_NODES) entries sets up the
// bucket heads and the free list; s_axis_tready stays low meanwhile.
// The front hashes each key by restoring division, one remainder bit per cycle, and
// takes a new item only after it has pushed the last job into the queue. The back
// handles inserts in B_HEAD and B_INS, lookups and removes in B_NODE (plus B_REM).
// A two-entry queue and the output register let each side stall on its own.
module chained_hash_table_engine_top #(
    parameter int MAX_BUCKETS = cht_pkg::DEF_MAX_BUCKETS,
    parameter int POOL_NODES  = cht_pkg::DEF_POOL_NODES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [cht_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [71:0]               s_axis_tdata,  // opcode, key_id, record_payload
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [39:0]               m_axis_tdata   // status, found_payload
);
    import cht_pkg::*;

    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int JW = OP_W + KEY_W + PAY_W + BW;

    logic [CFG_W-1:0] r_bucket_count;
    logic             w_init_done;
    logic             w_push, w_full, w_pop, w_qvalid;
    logic [JW-1:0]    w_fjob, w_qjob;
    logic [ST_W-1:0]  w_status;
    logic [PAY_W-1:0] w_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_bucket_count <= i_cfg_wdata;
        end
    end

    cht_front #(
        .MAX_BUCKETS(MAX_BUCKETS),
        .BW(BW),
        .JW(JW)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_en(w_init_done),
        .i_bucket_count(r_bucket_count),
        .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready),
        .i_op(s_axis_tdata[1:0]),
        .i_key(s_axis_tdata[32:2]),
        .i_payload(s_axis_tdata[64:33]),
        .o_push(w_push),
        .i_full(w_full),
        .o_job(w_fjob)
    );

    cht_queue #(
        .W(JW)
    ) u_queue (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(w_push),
        .i_data(w_fjob),
        .o_full(w_full),
        .i_pop(w_pop),
        .o_valid(w_qvalid),
        .o_data(w_qjob)
    );

    cht_back #(
        .MAX_BUCKETS(MAX_BUCKETS),
        .POOL_NODES(POOL_NODES),
        .BW(BW),
        .JW(JW)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .o_init_done(w_init_done),
        .i_job_valid(w_qvalid),
        .i_job(w_qjob),
        .o_job_pop(w_pop),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_status(w_status),
        .o_found(w_found)
    );

    assign m_axis_tdata = {6'd0, w_found, w_status};

endmodule
